// ----- sv/gdw_pkg.sv -----
// shared types, constants and helpers for the greedy density walker
// no dependencies; imported by greedy_density_walker_core
package gdw_pkg;

	// grid and field sizes
	localparam int GRID_ROWS_DEF = 128;
	localparam int GRID_COLS_DEF = 128;
	localparam int POS_W         = 7;
	localparam int LIM_W         = 8;
	localparam int TARGET_W      = 16;
	localparam int COUNT_W       = 24;
	localparam int SCORE_W       = COUNT_W + 1;
	localparam int POS_LIMIT     = 128;
	localparam int NUM_CAND      = 8;
	localparam int CAND_W        = 4;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// configuration registers
	localparam int CFG_AW                  = 3;
	localparam int CFG_DW                  = 32;
	localparam logic REG_ROWS              = 1'b0;
	localparam logic REG_COLS              = 1'b1;
	localparam logic [LIM_W-1:0] ROWS_RST  = 8'd100;
	localparam logic [LIM_W-1:0] COLS_RST  = 8'd100;

	// item opcodes
	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_STEP = 2'd1,
		OP_READ = 2'd2
	} op_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDATA,
		ST_INC,
		ST_SCAN
	} state_t;

	// neighbour offset along one axis
	typedef enum logic [1:0] {
		OFF_NEG,
		OFF_ZERO,
		OFF_POS
	} off_t;

	typedef struct packed {
		off_t dr;
		off_t dc;
	} cand_off_t;

	typedef struct packed {
		logic             ok;
		logic [POS_W-1:0] v;
	} axis_t;

	// scan order: row offset outer, column offset inner, centre skipped
	function automatic cand_off_t cand_offset(input logic [2:0] k);
		cand_off_t o;
		o = '{dr: OFF_ZERO, dc: OFF_ZERO};
		case (k)
			3'd0: o = '{dr: OFF_NEG,  dc: OFF_NEG};
			3'd1: o = '{dr: OFF_NEG,  dc: OFF_ZERO};
			3'd2: o = '{dr: OFF_NEG,  dc: OFF_POS};
			3'd3: o = '{dr: OFF_ZERO, dc: OFF_NEG};
			3'd4: o = '{dr: OFF_ZERO, dc: OFF_POS};
			3'd5: o = '{dr: OFF_POS,  dc: OFF_NEG};
			3'd6: o = '{dr: OFF_POS,  dc: OFF_ZERO};
			3'd7: o = '{dr: OFF_POS,  dc: OFF_POS};
			default: o = '{dr: OFF_ZERO, dc: OFF_ZERO};
		endcase
		return o;
	endfunction

	// move one coordinate by an offset and check it against the area limit
	function automatic axis_t step_axis(input off_t o, input logic [POS_W-1:0] p,
			input logic [LIM_W-1:0] lim);
		axis_t a;
		a.ok = 1'b0;
		a.v  = p;
		case (o)
			OFF_NEG: begin
				// p - 1 must stay inside the area even when p lies beyond it
				a.ok = (p != '0) && ({1'b0, p} <= lim);
				a.v  = p - POS_W'(1);
			end
			OFF_POS: begin
				a.ok = (({1'b0, p} + LIM_W'(1)) < lim);
				a.v  = p + POS_W'(1);
			end
			default: begin
				a.ok = ({1'b0, p} < lim);
				a.v  = p;
			end
		endcase
		return a;
	endfunction

	// clamp a register value to [1, top]
	function automatic logic [LIM_W-1:0] clamp_lim(input logic [LIM_W-1:0] r,
			input logic [LIM_W-1:0] top);
		logic [LIM_W-1:0] l;
		l = r;
		if (l == '0) begin
			l = LIM_W'(1);
		end
		if (l > top) begin
			l = top;
		end
		return l;
	endfunction

endpackage

// ----- sv/gdw_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies; used for the target and visit grids
module gdw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/greedy_density_walker_core.sv -----
// greedy density walker: load done is registered from the accept, read passes
// ST_RDATA, step ST_INC and ST_SCAN with eight neighbour reads via the single
// read port of each grid ram. load and the unused opcode keep busy low, read and
// step hold it high. results come as a one-cycle done strobe; the receiver cannot
// stall. after reset the visit grid is zeroed at GRID_ROWS * 2**clog2(GRID_COLS)
// addresses (16384 by default), busy stays high meanwhile; config writes still land
module greedy_density_walker_core
	import gdw_pkg::*;
#(
	parameter int GRID_ROWS = GRID_ROWS_DEF,
	parameter int GRID_COLS = GRID_COLS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// item channel
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          opcode,
	input  logic [POS_W-1:0]    cell_row,
	input  logic [POS_W-1:0]    cell_col,
	input  logic [TARGET_W-1:0] target_value,
	// result channel
	output logic                done,
	output logic [POS_W-1:0]    walker_row,
	output logic [POS_W-1:0]    walker_col,
	output logic [COUNT_W-1:0]  count_read,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CFG_AW-1:0]   paddr,
	input  logic [CFG_DW-1:0]   pwdata,
	output logic [CFG_DW-1:0]   prdata,
	output logic                pready
);

	localparam int COL_AW  = $clog2(GRID_COLS);
	localparam int DEPTH   = GRID_ROWS * (2 ** COL_AW);
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int ROW_TOP = (GRID_ROWS < POS_LIMIT) ? GRID_ROWS : POS_LIMIT;
	localparam int COL_TOP = (GRID_COLS < POS_LIMIT) ? GRID_COLS : POS_LIMIT;
	localparam logic [LIM_W-1:0] ROW_TOP_L = LIM_W'(ROW_TOP);
	localparam logic [LIM_W-1:0] COL_TOP_L = LIM_W'(COL_TOP);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] r,
			input logic [POS_W-1:0] c);
		return ADDR_W'((32'(r) << COL_AW) | 32'(c));
	endfunction

	// registers
	state_t               state_q, state_d;
	logic [ADDR_W-1:0]    clr_q;
	logic [LIM_W-1:0]     rows_q, cols_q;
	logic [POS_W-1:0]     pos_row_q, pos_col_q;
	logic                 done_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 rd_inside_q;
	logic [CAND_W-1:0]    scan_k_q;
	logic                 found_q;
	logic signed [SCORE_W-1:0] best_q;
	logic [POS_W-1:0]     best_r_q, best_c_q;
	logic                 cand_ok_s1;
	logic [POS_W-1:0]     cand_r_s1, cand_c_s1;

	// combinational
	logic                 accept;
	logic                 in_grid;
	logic [LIM_W-1:0]     lim_r, lim_c;
	logic [2:0]           iss_k;
	cand_off_t            iss_off;
	axis_t                ax_r, ax_c;
	logic [TARGET_W-1:0]  t_rdata;
	logic [COUNT_W-1:0]   v_rdata;
	logic                 t_we, v_we;
	logic [ADDR_W-1:0]    t_waddr, v_waddr, t_raddr, v_raddr;
	logic [COUNT_W-1:0]   v_wdata;
	logic signed [SCORE_W-1:0] score;
	logic                 take;
	logic                 cfg_wr;

	assign accept  = start && !busy;
	assign busy    = (state_q != ST_IDLE);
	assign in_grid = (32'(cell_row) < 32'(GRID_ROWS)) && (32'(cell_col) < 32'(GRID_COLS));
	assign lim_r   = clamp_lim(rows_q, ROW_TOP_L);
	assign lim_c   = clamp_lim(cols_q, COL_TOP_L);

	// candidate issued this cycle
	assign iss_k   = (state_q == ST_INC) ? 3'd0 : scan_k_q[2:0];
	assign iss_off = cand_offset(iss_k);
	assign ax_r    = step_axis(iss_off.dr, pos_row_q, lim_r);
	assign ax_c    = step_axis(iss_off.dc, pos_col_q, lim_c);

	// candidate scoring, data from the previous cycle's read
	assign score = $signed({{(SCORE_W-TARGET_W){1'b0}}, t_rdata})
		- $signed({1'b0, v_rdata});
	assign take  = (state_q == ST_SCAN) && cand_ok_s1 && (!found_q || (score > best_q));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (opcode)
						OP_STEP: state_d = ST_INC;
						OP_READ: state_d = ST_RDATA;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_RDATA: state_d = ST_IDLE;
			ST_INC:   state_d = ST_SCAN;
			ST_SCAN: begin
				if (scan_k_q == CAND_W'(NUM_CAND)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ram control
	always_comb begin
		t_we    = 1'b0;
		t_waddr = cell_addr(cell_row, cell_col);
		t_raddr = cell_addr(ax_r.v, ax_c.v);
		v_we    = 1'b0;
		v_waddr = cell_addr(pos_row_q, pos_col_q);
		v_wdata = (v_rdata == COUNT_MAX) ? v_rdata : v_rdata + COUNT_W'(1);
		v_raddr = cell_addr(ax_r.v, ax_c.v);
		case (state_q)
			ST_CLEAR: begin
				v_we    = 1'b1;
				v_waddr = clr_q;
				v_wdata = '0;
			end
			ST_IDLE: begin
				t_we = accept && (opcode == OP_LOAD) && in_grid;
				if (opcode == OP_STEP) begin
					v_raddr = cell_addr(pos_row_q, pos_col_q);
				end else begin
					v_raddr = cell_addr(cell_row, cell_col);
				end
			end
			ST_INC: begin
				// saturating count of the walker's own cell
				v_we = 1'b1;
			end
			default: begin
				t_we = 1'b0;
			end
		endcase
	end

	gdw_ram #(
		.WIDTH(TARGET_W),
		.DEPTH(DEPTH)
	) u_target_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (target_value),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	gdw_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(DEPTH)
	) u_visit_ram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	// sequencer and walker registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			pos_row_q  <= '0;
			pos_col_q  <= '0;
			done_q     <= 1'b0;
			scan_k_q   <= '0;
			found_q    <= 1'b0;
			cand_ok_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (state_q == ST_IDLE && accept && opcode != OP_STEP && opcode != OP_READ) begin
				done_q <= 1'b1;
			end
			if (state_q == ST_RDATA) begin
				done_q <= 1'b1;
			end
			// candidate pipeline
			cand_ok_s1 <= ax_r.ok && ax_c.ok
				&& (state_q == ST_INC || (state_q == ST_SCAN && scan_k_q != CAND_W'(NUM_CAND)));
			if (state_q == ST_INC) begin
				scan_k_q <= CAND_W'(1);
				found_q  <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				scan_k_q <= scan_k_q + CAND_W'(1);
				if (take) begin
					found_q <= 1'b1;
				end
				if (scan_k_q == CAND_W'(NUM_CAND)) begin
					done_q    <= 1'b1;
					pos_row_q <= take ? cand_r_s1 : best_r_q;
					pos_col_q <= take ? cand_c_s1 : best_c_q;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cand_r_s1 <= ax_r.v;
		cand_c_s1 <= ax_c.v;
		if (state_q == ST_INC) begin
			best_r_q <= pos_row_q;
			best_c_q <= pos_col_q;
		end else if (take) begin
			best_q   <= score;
			best_r_q <= cand_r_s1;
			best_c_q <= cand_c_s1;
		end
		if (state_q == ST_IDLE && accept) begin
			rd_inside_q <= in_grid;
			count_q     <= '0;
		end else if (state_q == ST_RDATA) begin
			count_q <= rd_inside_q ? v_rdata : '0;
		end else if (state_q == ST_INC) begin
			count_q <= '0;
		end
	end

	// configuration registers
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RST;
			cols_q <= COLS_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ROWS) begin
				rows_q <= pwdata[LIM_W-1:0];
			end else begin
				cols_q <= pwdata[LIM_W-1:0];
			end
		end
	end

	assign prdata = {{(CFG_DW-LIM_W){1'b0}}, (paddr[2] == REG_COLS) ? cols_q : rows_q};

	// result ports
	assign done       = done_q;
	assign walker_row = pos_row_q;
	assign walker_col = pos_col_q;
	assign count_read = count_q;

	// checks
	a_step_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept && opcode == OP_STEP |-> ##10 done_q)
		else $error("step result not after ten cycles");

	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept && opcode == OP_READ |-> ##2 done_q)
		else $error("read result not after two cycles");

	a_pos_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(pos_row_q) < 32'(ROW_TOP)) && (32'(pos_col_q) < 32'(COL_TOP)))
		else $error("walker outside grid");

	a_no_result_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |=> !done_q)
		else $error("result during clearing pass");

endmodule

// ----- sim/tb_greedy_density_walker_core.sv -----
// self-checking testbench for greedy_density_walker_core: drives item transfers and register
// writes, predicts every result with a scoreboard copy of both grids and the walker position
// depends on gdw_pkg and greedy_density_walker_core
module tb_greedy_density_walker_core
	import gdw_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELLS       = GRID_ROWS_DEF * GRID_COLS_DEF;
	localparam int LAST_POS    = GRID_ROWS_DEF - 1;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam logic [CFG_AW-1:0] ADDR_ROWS = {REG_ROWS, 2'b00};
	localparam logic [CFG_AW-1:0] ADDR_COLS = {REG_COLS, 2'b00};

	typedef struct packed {
		logic [1:0]          opcode;
		logic [POS_W-1:0]    row;
		logic [POS_W-1:0]    col;
		logic [TARGET_W-1:0] target;
	} walk_item_t;

	typedef struct packed {
		logic [POS_W-1:0]   row;
		logic [POS_W-1:0]   col;
		logic [COUNT_W-1:0] count;
	} walk_result_t;

	// block ports
	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic [1:0]          opcode = OP_LOAD;
	logic [POS_W-1:0]    cell_row = '0;
	logic [POS_W-1:0]    cell_col = '0;
	logic [TARGET_W-1:0] target_value = '0;
	logic                done;
	logic [POS_W-1:0]    walker_row;
	logic [POS_W-1:0]    walker_col;
	logic [COUNT_W-1:0]  count_read;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [CFG_AW-1:0]   paddr = '0;
	logic [CFG_DW-1:0]   pwdata = '0;
	logic [CFG_DW-1:0]   prdata;
	logic                pready;

	// scoreboard copy of the block state
	logic [TARGET_W-1:0] target_mem [CELLS];
	bit                  target_set [CELLS];
	logic [COUNT_W-1:0]  visit_mem [CELLS];
	logic [POS_W-1:0]    pos_r;
	logic [POS_W-1:0]    pos_c;
	logic [LIM_W-1:0]    rows_reg;
	logic [LIM_W-1:0]    cols_reg;

	walk_item_t   pending_items [$];
	walk_result_t expected_walks [$];
	walk_item_t   cur_item;
	walk_result_t want;
	bit           took;
	int           gap_left = 0;
	int           burst_left = 0;
	int           fail_count = 0;
	int           cycle_count = 0;
	int           n_items = 0;
	int           n_steps = 0;
	int           n_settings = 0;

	greedy_density_walker_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.cell_row     (cell_row),
		.cell_col     (cell_col),
		.target_value (target_value),
		.done         (done),
		.walker_row   (walker_row),
		.walker_col   (walker_col),
		.count_read   (count_read),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// area limit from a register: zero counts as one, capped at the grid
	function automatic int area_lim(input logic [LIM_W-1:0] r);
		int l;
		l = (r == '0) ? 1 : int'(r);
		if (l > POS_LIMIT) begin
			l = POS_LIMIT;
		end
		return l;
	endfunction

	function automatic bit in_area(input int r, input int c);
		return r >= 0 && c >= 0 && r < area_lim(rows_reg) && c < area_lim(cols_reg);
	endfunction

	function automatic int cell_at(input int r, input int c);
		return r * GRID_COLS_DEF + c;
	endfunction

	// apply one item to the scoreboard state and return the walker result it causes
	function automatic walk_result_t apply_walk_item(input walk_item_t it);
		walk_result_t res;
		int here, k, r, c, score, best, nr, nc;
		bit found;
		res.count = '0;
		case (it.opcode)
			OP_LOAD: begin
				target_mem[cell_at(it.row, it.col)] = it.target;
				target_set[cell_at(it.row, it.col)] = 1'b1;
			end
			OP_STEP: begin
				here = cell_at(pos_r, pos_c);
				if (visit_mem[here] != COUNT_MAX) begin
					visit_mem[here] = visit_mem[here] + 1'b1;
				end
				// scan row offset outer, column offset inner; strict compare keeps the first
				found = 1'b0;
				best = 0;
				nr = pos_r;
				nc = pos_c;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						r = int'(pos_r) + dr;
						c = int'(pos_c) + dc;
						if ((dr != 0 || dc != 0) && in_area(r, c)) begin
							k = cell_at(r, c);
							score = int'(target_mem[k]) - int'(visit_mem[k]);
							if (!found || score > best) begin
								found = 1'b1;
								best = score;
								nr = r;
								nc = c;
							end
						end
					end
				end
				pos_r = POS_W'(nr);
				pos_c = POS_W'(nc);
			end
			OP_READ: begin
				res.count = visit_mem[cell_at(it.row, it.col)];
			end
			default: begin
			end
		endcase
		res.row = pos_r;
		res.col = pos_c;
		return res;
	endfunction

	// idle length before the next item: mostly none, some short, a few long, bursts with none
	function automatic int pick_gap();
		int roll;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 2) begin
			burst_left = $urandom_range(30, 80);
			return 0;
		end
		if (roll < 55) begin
			return 0;
		end
		if (roll < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(4, 40);
	endfunction

	// item driver: one transfer per start high while busy is low
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			opcode <= OP_LOAD;
			cell_row <= '0;
			cell_col <= '0;
			target_value <= '0;
		end else begin
			took = start && !busy;
			if (took) begin
				expected_walks.push_back(apply_walk_item(cur_item));
				n_items++;
				if (cur_item.opcode == OP_STEP) begin
					n_steps++;
				end
				gap_left = pick_gap();
			end
			if (!start || took) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_items.size() != 0) begin
					cur_item = pending_items.pop_front();
					start <= 1'b1;
					opcode <= cur_item.opcode;
					cell_row <= cur_item.row;
					cell_col <= cur_item.col;
					target_value <= cur_item.target;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor: each done strobe is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_walks.size() == 0) begin
				$display("%0t: result with none expected: row %0d col %0d count %0d",
					$time, walker_row, walker_col, count_read);
				fail_count++;
			end else begin
				want = expected_walks.pop_front();
				if (walker_row !== want.row) begin
					$display("%0t: walker_row expected %0d, got %0d", $time, want.row, walker_row);
					fail_count++;
				end
				if (walker_col !== want.col) begin
					$display("%0t: walker_col expected %0d, got %0d", $time, want.col, walker_col);
					fail_count++;
				end
				if (count_read !== want.count) begin
					$display("%0t: count_read expected %0d, got %0d", $time, want.count,
						count_read);
					fail_count++;
				end
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timed out with %0d results outstanding", $time, expected_walks.size());
			$display("tb: failure");
			$finish;
		end
	end

	task automatic push_item(input logic [1:0] op, input logic [POS_W-1:0] row,
			input logic [POS_W-1:0] col, input logic [TARGET_W-1:0] tv);
		walk_item_t it;
		it.opcode = op;
		it.row = row;
		it.col = col;
		it.target = tv;
		pending_items.push_back(it);
	endtask

	// wait until every queued item has been transferred
	task automatic settle();
		while (pending_items.size() != 0 || start) begin
			@(negedge clk);
		end
	endtask

	// wait until every expected result has come back too
	task automatic drain();
		settle();
		while (expected_walks.size() != 0) begin
			@(negedge clk);
		end
	endtask

	function automatic logic [TARGET_W-1:0] rand_target();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll == 0) begin
			return '1;
		end
		if (roll < 14) begin
			return TARGET_W'($urandom_range(0, 7));
		end
		return TARGET_W'($urandom());
	endfunction

	function automatic logic [POS_W-1:0] near(input logic [POS_W-1:0] p, input int span);
		int v;
		v = int'(p) + int'($urandom_range(0, 2 * span)) - span;
		if (v < 0) begin
			v = 0;
		end
		if (v > LAST_POS) begin
			v = LAST_POS;
		end
		return POS_W'(v);
	endfunction

	function automatic logic [LIM_W-1:0] pick_lim();
		int roll;
		roll = $urandom_range(0, 9);
		case (roll)
			0: return LIM_W'(0);
			1: return LIM_W'(1);
			2: return LIM_W'(2);
			3: return LIM_W'(127);
			4: return LIM_W'(128);
			5: return LIM_W'(255);
			default: return LIM_W'($urandom_range(3, 24));
		endcase
	endfunction

	// load any in-area neighbour of the walker whose target was never written
	task automatic fill_around();
		int r, c;
		settle();
		for (int dr = -1; dr <= 1; dr++) begin
			for (int dc = -1; dc <= 1; dc++) begin
				r = int'(pos_r) + dr;
				c = int'(pos_c) + dc;
				if ((dr != 0 || dc != 0) && in_area(r, c) && !target_set[cell_at(r, c)]) begin
					push_item(OP_LOAD, POS_W'(r), POS_W'(c), rand_target());
				end
			end
		end
	endtask

	task automatic step_item();
		fill_around();
		push_item(OP_STEP, POS_W'($urandom()), POS_W'($urandom()), TARGET_W'($urandom()));
	endtask

	// one register transfer: setup cycle, then access cycle until pready
	task automatic reg_access(input logic wr, input logic [CFG_AW-1:0] addr,
			input logic [CFG_DW-1:0] wdata, output logic [CFG_DW-1:0] rdata);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		rdata = prdata;
		if (wr) begin
			if (addr == ADDR_ROWS) begin
				rows_reg = wdata[LIM_W-1:0];
			end else if (addr == ADDR_COLS) begin
				cols_reg = wdata[LIM_W-1:0];
			end
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_regs();
		logic [CFG_DW-1:0] rd;
		reg_access(1'b0, ADDR_ROWS, $urandom(), rd);
		if (rd !== CFG_DW'(rows_reg)) begin
			$display("%0t: rows_in_use read expected %0d, got %0d", $time, rows_reg, rd);
			fail_count++;
		end
		reg_access(1'b0, ADDR_COLS, $urandom(), rd);
		if (rd !== CFG_DW'(cols_reg)) begin
			$display("%0t: cols_in_use read expected %0d, got %0d", $time, cols_reg, rd);
			fail_count++;
		end
	endtask

	// new area, written only once the block has gone quiet
	task automatic set_area(input logic [LIM_W-1:0] rows, input logic [LIM_W-1:0] cols);
		logic [CFG_DW-1:0] rd;
		drain();
		reg_access(1'b1, ADDR_ROWS, {(CFG_DW - LIM_W)'($urandom()), rows}, rd);
		reg_access(1'b1, ADDR_COLS, {(CFG_DW - LIM_W)'($urandom()), cols}, rd);
		check_regs();
		n_settings++;
	endtask

	// stimulus
	initial begin : stimulus
		int guard;
		int roll;
		for (int k = 0; k < CELLS; k++) begin
			target_mem[k] = '0;
			target_set[k] = 1'b0;
			visit_mem[k] = '0;
		end
		pos_r = '0;
		pos_c = '0;
		rows_reg = ROWS_RST;
		cols_reg = COLS_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		check_regs();

		// field extremes and the unused opcode
		push_item(OP_LOAD, '0, '0, '0);
		push_item(OP_LOAD, '1, '1, '1);
		push_item(OP_READ, '1, '1, '0);
		push_item(OP_READ, '0, '1, '1);
		push_item(OP_SPARE, '1, '1, '1);
		push_item(OP_SPARE, '0, '0, '0);

		// three equal neighbours: the first in scan order takes the walker
		push_item(OP_LOAD, POS_W'(0), POS_W'(1), TARGET_W'(5));
		push_item(OP_LOAD, POS_W'(1), POS_W'(0), TARGET_W'(5));
		push_item(OP_LOAD, POS_W'(1), POS_W'(1), TARGET_W'(5));
		step_item();
		push_item(OP_READ, POS_W'(0), POS_W'(0), '1);

		// one column only, walker starts outside it; steer down to the bottom row
		set_area(LIM_W'(255), LIM_W'(0));
		guard = 0;
		while (int'(pos_r) != LAST_POS && guard < 2 * GRID_ROWS_DEF) begin
			fill_around();
			push_item(OP_LOAD, POS_W'(int'(pos_r) + 1), '0, '1);
			push_item(OP_STEP, '1, '1, '1);
			settle();
			guard++;
		end
		// bottom edge: the row below is off the grid
		step_item();

		// area shrunk to one cell with the walker outside: no candidate, walker stays
		set_area(LIM_W'(0), LIM_W'(0));
		step_item();
		step_item();
		settle();
		push_item(OP_READ, pos_r, pos_c, '0);

		// random phases, mostly walks through small areas
		for (int ph = 0; ph < 12; ph++) begin
			if (ph == 0) begin
				set_area(LIM_W'(128), LIM_W'(128));
			end else begin
				set_area(pick_lim(), pick_lim());
			end
			for (int n = 0; n < 50; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 55) begin
					step_item();
				end else if (roll < 63) begin
					push_item(OP_LOAD, near(pos_r, 2), near(pos_c, 2), rand_target());
				end else if (roll < 70) begin
					push_item(OP_LOAD, POS_W'($urandom()), POS_W'($urandom()), rand_target());
				end else if (roll < 80) begin
					push_item(OP_READ, near(pos_r, 1), near(pos_c, 1), TARGET_W'($urandom()));
				end else if (roll < 90) begin
					push_item(OP_READ, POS_W'($urandom()), POS_W'($urandom()),
						TARGET_W'($urandom()));
				end else begin
					push_item(OP_SPARE, POS_W'($urandom()), POS_W'($urandom()),
						TARGET_W'($urandom()));
				end
			end
		end

		// wind down
		drain();
		repeat (20) @(posedge clk);
		$display("run covered %0d items, %0d of them walk steps, over %0d area settings",
			n_items, n_steps, n_settings);
		$display("walker finished at row %0d column %0d", pos_r, pos_c);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
